FILE: rtl/tstb_pkg.sv
// Package for the task sleep timer bank.
// Holds the request and response payload types and the mode codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tstb_pkg;

  localparam int IdBits   = 3;
  localparam int TimeIn   = 32;
  localparam int MaskBits = 8;

  localparam logic MODE_SLEEP = 1'b0;
  localparam logic MODE_TICK  = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [IdBits-1:0] task_id;
    logic [TimeIn-1:0] sleep_time;
  } req_t;

  typedef struct packed {
    logic [MaskBits-1:0] woken_mask;
    logic [MaskBits-1:0] runnable_mask;
  } rsp_t;

  typedef logic [MaskBits-1:0] cfg_t;

endpackage

`default_nettype wire

FILE: rtl/tstb_chan_if.sv
// Valid/ready channel interface used for requests, responses and configuration.
// The payload type is a parameter; types come from tstb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tstb_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/task_sleep_timer_bank_top.sv
// Task sleep timer bank: one sleep counter and asleep flag per task.
// Depends on tstb_pkg, tstb_chan_if and tstb_ram.
//
// Usage:
// A request on req either puts one task to sleep (mode MODE_SLEEP, task_id,
// sleep_time) or advances time by one tick (mode MODE_TICK). Each request
// produces exactly one response on rsp with the mask of tasks woken by it and
// the mask of enabled tasks that are awake afterwards. The cfg channel writes
// the task enable register; it is always ready. The user is to write it only
// while idle; the block does not enforce this. A sleep request goes from idle
// to the finish state, which loads the response register once it is free and
// returns to idle to take the next request. A tick walks the counters one task
// per cycle through a single decrementer and the counter RAM, whose registered
// read port reads each counter ahead of its decrement, then finishes the same
// way. A finished response is held in an output register, so a new request is
// accepted while it waits; if the receiver still stalls when the next response
// is ready, the sequencer waits for the register to drain.
// Reset clears all asleep flags, the enable register and the response valid.
`timescale 1ns / 1ps
`default_nettype none

module task_sleep_timer_bank_top
  import tstb_pkg::*;
#(
  parameter int TASKS     = 8,
  parameter int TIME_BITS = 32
) (
  input wire logic clk,
  input wire logic rst,
  tstb_chan_if.sink   req,
  tstb_chan_if.source rsp,
  tstb_chan_if.sink   cfg
);

  localparam int AW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int CW = $clog2(TASKS + 1);
  localparam logic [63:0] TimeMax = (64'd1 << TIME_BITS) - 64'd1;
  localparam logic [CW-1:0] LastStep = CW'(TASKS);
  localparam logic [MaskBits-1:0] TaskMask =
    (TASKS >= MaskBits) ? {MaskBits{1'b1}} : MaskBits'((64'd1 << TASKS) - 64'd1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_t;

  state_t                state;
  logic [CW-1:0]         step;
  logic [TASKS-1:0]      asleep;
  logic [TASKS-1:0]      woken;
  logic [MaskBits-1:0]   task_enable;

  logic                  req_fire;
  logic                  id_ok;
  logic [63:0]           t_wide;
  logic [TIME_BITS-1:0]  load_val;
  logic [CW-1:0]         prev_step;
  logic [AW-1:0]         proc_idx;
  logic                  proc_active;
  logic [TIME_BITS-1:0]  rd_data;
  logic [TIME_BITS-1:0]  dec_val;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [TIME_BITS-1:0]  ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [IdBits+4:0]     id_wide;
  logic                  slot_free;

  assign req.ready = (state == ST_IDLE);
  assign cfg.ready = 1'b1;
  assign req_fire  = req.valid && req.ready;
  assign slot_free = !rsp.valid || rsp.ready;

  assign id_wide = (IdBits + 5)'(req.data.task_id);
  assign id_ok   = (32'(id_wide) < TASKS);

  always_comb begin
    t_wide = 64'(req.data.sleep_time);
    if (t_wide > TimeMax) begin
      t_wide = TimeMax;
    end
    if (t_wide == 64'd0) begin
      t_wide = 64'd1;
    end
    load_val = t_wide[TIME_BITS-1:0];
  end

  assign prev_step   = step - CW'(1);
  assign proc_idx    = prev_step[AW-1:0];
  assign proc_active = (state == ST_WALK) && (step != '0);
  assign dec_val     = rd_data - TIME_BITS'(1);
  assign ram_raddr   = (step < LastStep) ? step[AW-1:0] : '0;

  always_comb begin
    if (state == ST_IDLE) begin
      ram_we    = req_fire && (req.data.mode == MODE_SLEEP) && id_ok;
      ram_waddr = id_wide[AW-1:0];
      ram_wdata = load_val;
    end else begin
      ram_we    = proc_active && asleep[proc_idx];
      ram_waddr = proc_idx;
      ram_wdata = dec_val;
    end
  end

  tstb_ram #(
    .WIDTH (TIME_BITS),
    .DEPTH (TASKS)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      asleep      <= '0;
      woken       <= '0;
      task_enable <= '0;
      rsp.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        task_enable <= cfg.data;
      end
      if (rsp.valid && rsp.ready && (state != ST_FINISH)) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            woken <= '0;
            step  <= '0;
            if (req.data.mode == MODE_TICK) begin
              state <= ST_WALK;
            end else begin
              if (id_ok) begin
                asleep[id_wide[AW-1:0]] <= 1'b1;
              end
              state <= ST_FINISH;
            end
          end
        end
        ST_WALK: begin
          if (proc_active && asleep[proc_idx] && (dec_val == '0)) begin
            asleep[proc_idx] <= 1'b0;
            woken[proc_idx]  <= 1'b1;
          end
          if (step == LastStep) begin
            state <= ST_FINISH;
          end else begin
            step <= step + CW'(1);
          end
        end
        ST_FINISH: begin
          if (slot_free) begin
            rsp.valid              <= 1'b1;
            rsp.data.woken_mask    <= MaskBits'(woken);
            rsp.data.runnable_mask <= task_enable & ~MaskBits'(asleep) & TaskMask;
            state                  <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A task is never reported woken while still asleep.
  a_woken_awake: assert property (@(posedge clk) disable iff (rst)
    (woken & asleep) == '0)
    else $error("woken task still marked asleep");

  // A new response is only produced by the finish step of the sequencer.
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == ST_FINISH)
    else $error("response raised outside the finish step");

  // The request channel stays closed during the counter walk.
  a_walk_no_req: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> !req.ready)
    else $error("request channel ready during the counter walk");

  // A sleep request wakes no task.
  a_sleep_no_wake: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.data.mode == MODE_SLEEP) |=> woken == '0)
    else $error("sleep request reported a woken task");

endmodule

`default_nettype wire

FILE: rtl/tstb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tstb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: tb/sv/tb_task_sleep_timer_bank_top.sv
// Self-checking testbench for the task sleep timer bank.
// Drives sleep and tick requests with random gaps and checks each response against a predictor.
// Depends on tstb_pkg, tstb_chan_if and task_sleep_timer_bank_top.
`timescale 1ns / 1ps

module tb_task_sleep_timer_bank_top;
  import tstb_pkg::*;

  localparam int BankTasks  = 8;
  localparam int TimeBits   = 32;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 125;

  logic clk;
  logic rst;

  tstb_chan_if #(.payload_t(req_t)) req_ch ();
  tstb_chan_if #(.payload_t(rsp_t)) rsp_ch ();
  tstb_chan_if #(.payload_t(cfg_t)) cfg_ch ();

  task_sleep_timer_bank_top #(
    .TASKS(BankTasks),
    .TIME_BITS(TimeBits)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  logic [TimeBits-1:0] sleep_left [BankTasks];
  logic [BankTasks-1:0] asleep_set = '0;
  cfg_t                 enabled_set = '0;

  req_t request_backlog [$];
  rsp_t masks_due [$];
  int   requests_queued = 0;
  int   responses_seen = 0;
  int   mismatches = 0;
  int   cycle_count = 0;
  int   req_hold = 0;
  int   rsp_hold = 0;
  bit   req_calm = 0;
  bit   rsp_calm = 0;

  function automatic rsp_t predict_masks(req_t r);
    rsp_t                 o;
    logic [BankTasks-1:0] woken;
    woken = '0;
    if (r.mode == MODE_SLEEP) begin
      sleep_left[r.task_id] = (r.sleep_time == '0) ? TimeBits'(1) : r.sleep_time;
      asleep_set[r.task_id] = 1'b1;
    end else begin
      for (int i = 0; i < BankTasks; i++) begin
        if (asleep_set[i]) begin
          sleep_left[i] = sleep_left[i] - 1'b1;
          if (sleep_left[i] == '0) begin
            asleep_set[i] = 1'b0;
            woken[i] = 1'b1;
          end
        end
      end
    end
    o.woken_mask = woken;
    o.runnable_mask = enabled_set & ~asleep_set;
    return o;
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.mode = ($urandom_range(0, 99) < 45) ? MODE_TICK : MODE_SLEEP;
    r.task_id = IdBits'($urandom_range(0, BankTasks - 1));
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      r.sleep_time = $urandom_range(0, 6);
    end else if (pick < 85) begin
      r.sleep_time = $urandom_range(0, 40);
    end else begin
      r.sleep_time = $urandom();
    end
    return r;
  endfunction

  task automatic queue_request(logic mode, logic [IdBits-1:0] id, logic [TimeIn-1:0] ticks);
    req_t r;
    r.mode = mode;
    r.task_id = id;
    r.sleep_time = ticks;
    request_backlog.push_back(r);
    requests_queued++;
  endtask

  task automatic write_enable(cfg_t value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    enabled_set = value;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic drain_bank();
    while (responses_seen < requests_queued) @(posedge clk);
    repeat (BankTasks + 4) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout with %0d responses outstanding", $time,
               requests_queued - responses_seen);
      $display("** task_sleep_timer_bank_top: FAILED **");
      $finish;
    end
  end

  // Request driver: holds a request until it is taken, then waits a drawn gap.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        masks_due.push_back(predict_masks(req_ch.data));
        if ($urandom_range(0, 39) == 0) req_calm = !req_calm;
        req_hold = req_calm ? 0 : $urandom_range(0, 3);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_hold > 0) begin
          req_hold--;
          req_ch.valid <= 1'b0;
        end else if (request_backlog.size() > 0) begin
          req_ch.data <= request_backlog.pop_front();
          req_ch.valid <= 1'b1;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each response with the oldest expected masks.
  always @(posedge clk) begin
    rsp_t exp_masks;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        responses_seen++;
        if (masks_due.size() == 0) begin
          mismatches++;
          $display("%0t: response with no request pending: woken %h runnable %h",
                   $time, rsp_ch.data.woken_mask, rsp_ch.data.runnable_mask);
        end else begin
          exp_masks = masks_due.pop_front();
          if (exp_masks.woken_mask !== rsp_ch.data.woken_mask) begin
            mismatches++;
            $display("%0t: woken_mask expected %h actual %h", $time,
                     exp_masks.woken_mask, rsp_ch.data.woken_mask);
          end
          if (exp_masks.runnable_mask !== rsp_ch.data.runnable_mask) begin
            mismatches++;
            $display("%0t: runnable_mask expected %h actual %h", $time,
                     exp_masks.runnable_mask, rsp_ch.data.runnable_mask);
          end
        end
        if ($urandom_range(0, 39) == 0) rsp_calm = !rsp_calm;
        rsp_hold = rsp_calm ? 0 : $urandom_range(0, 3);
      end
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cfg_t phase_enable;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.data = '0;
    rsp_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    for (int i = 0; i < BankTasks; i++) sleep_left[i] = '0;
    req_calm = 1'($urandom_range(0, 1));
    rsp_calm = 1'($urandom_range(0, 1));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with every task enabled.
    write_enable(8'hFF);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_SLEEP, 3'd0, 32'd0);
    queue_request(MODE_TICK, 3'd7, 32'hFFFF_FFFF);
    queue_request(MODE_SLEEP, 3'd7, 32'hFFFF_FFFF);
    queue_request(MODE_SLEEP, 3'd3, 32'd2);
    queue_request(MODE_SLEEP, 3'd3, 32'd5);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_SLEEP, 3'd5, 32'd1);
    queue_request(MODE_SLEEP, 3'd2, 32'd1);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_SLEEP, 3'd7, 32'd1);
    queue_request(MODE_SLEEP, 3'd1, 32'h8000_0000);
    queue_request(MODE_SLEEP, 3'd6, 32'h7FFF_FFFF);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_SLEEP, 3'd1, 32'd0);
    queue_request(MODE_SLEEP, 3'd6, 32'd1);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    drain_bank();

    // A disabled task may sleep and wake but never shows as runnable.
    write_enable(8'h0F);
    queue_request(MODE_SLEEP, 3'd6, 32'd1);
    queue_request(MODE_SLEEP, 3'd2, 32'd2);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    queue_request(MODE_TICK, 3'd0, 32'd0);
    drain_bank();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin
          phase_enable = 8'h00;
        end
        1: begin
          phase_enable = 8'hFF;
        end
        4: begin
          phase_enable = 8'h55;
        end
        default: begin
          phase_enable = cfg_t'($urandom_range(0, 255));
        end
      endcase
      write_enable(phase_enable);
      for (int n = 0; n < PhaseItems; n++) begin
        request_backlog.push_back(random_request());
        requests_queued++;
      end
      drain_bank();
    end

    if (masks_due.size() != 0) begin
      mismatches++;
      $display("%0t: %0d expected responses never arrived", $time, masks_due.size());
    end
    if (mismatches == 0) begin
      $display("** task_sleep_timer_bank_top: PASSED **");
    end else begin
      $display("** task_sleep_timer_bank_top: FAILED **");
    end
    $finish;
  end

endmodule
